FILE: sv/nscas_pkg.sv
// Shared types and constants of the near-station carrot aim shaper.
package nscas_pkg;

  localparam int POS_W      = 32;
  localparam int VEL_W      = 24;
  localparam int FRAC_W     = 16;
  localparam int RAD_W      = 23;
  localparam int NMIN_W     = 24;
  localparam int DIST_W     = POS_W + 1;
  localparam int BLEND_W    = FRAC_W + 1;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_FAR  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOK = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NMIN = 4'd3;

  typedef enum logic [3:0] {
    RSN_NONE        = 4'd0,
    RSN_APPLIED     = 4'd1,
    RSN_BASE_BAD    = 4'd2,
    RSN_NOT_AIM     = 4'd3,
    RSN_NO_OWN_POS  = 4'd4,
    RSN_NO_TRACK    = 4'd5,
    RSN_TRACK_BAD   = 4'd6,
    RSN_GEOMETRY    = 4'd7,
    RSN_ARITH       = 4'd8,
    RSN_BEYOND_FAR  = 4'd9,
    RSN_TRACK_UNDEF = 4'd10
  } reason_t;

  typedef struct packed {
    logic                     is_owner;
    logic                     base_valid;
    logic                     route_is_aim_point;
    logic                     own_position_valid;
    logic                     track_available;
    logic                     track_finite;
    logic signed [POS_W-1:0]  aim_north;
    logic signed [POS_W-1:0]  aim_east;
    logic signed [POS_W-1:0]  own_north;
    logic signed [POS_W-1:0]  own_east;
    logic signed [VEL_W-1:0]  track_vel_north;
    logic signed [VEL_W-1:0]  track_vel_east;
  } in_t;

  typedef struct packed {
    logic                     evaluated;
    logic                     applied;
    logic [3:0]               reason_code;
    logic signed [POS_W-1:0]  out_north;
    logic signed [POS_W-1:0]  out_east;
    logic [DIST_W-1:0]        station_distance;
    logic [BLEND_W-1:0]       blend_fraction;
    logic [BLEND_W-1:0]       blend_weight;
    logic [VEL_W-1:0]         track_norm;
  } out_t;

  typedef struct packed {
    logic [RAD_W-1:0]  far;
    logic [RAD_W-1:0]  near;
    logic [RAD_W-1:0]  look;
    logic [NMIN_W-1:0] nmin;
  } cfg_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic                     owner;
    logic                     go;
    reason_t                  rsn;
    logic signed [POS_W-1:0]  an;
    logic signed [POS_W-1:0]  ae;
    logic [DIST_W-1:0]        dn_mag;
    logic [DIST_W-1:0]        de_mag;
    logic [VEL_W-1:0]         vn_mag;
    logic [VEL_W-1:0]         ve_mag;
    logic                     vn_neg;
    logic                     ve_neg;
  } job_t;

endpackage

FILE: sv/nscas_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module nscas_isqrt #(
  parameter int RW = 34
) (
  input  logic            clk,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);

  logic [2*RW-1:0] rad_q  [RW-1];
  logic [RW:0]     rem_q  [RW-1];
  logic [RW-1:0]   root_q [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [2*RW-1:0] rad_in;
    logic [RW:0]     rem_in;
    logic [RW-1:0]   root_in;
    logic [RW+2:0]   rem2;
    logic [RW+2:0]   trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign rem2  = {rem_in, rad_in[2*RW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk) begin
      root_q[i] <= {root_in[RW-2:0], ge};
    end

    if (i < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rad_q[i] <= {rad_in[2*RW-3:0], 2'b00};
        rem_q[i] <= (RW+1)'(ge ? rem2 - trial : rem2);
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

FILE: sv/nscas_div.sv
// Pipelined restoring divider, one quotient bit per stage; hi must be below den.
module nscas_div #(
  parameter int NW = 24,
  parameter int QW = 24
) (
  input  logic          clk,
  input  logic [NW-1:0] hi,
  input  logic [QW-1:0] lo,
  input  logic [NW-1:0] den,
  output logic [QW-1:0] q
);

  logic [NW-1:0] rem_q [QW-1];
  logic [QW-1:0] lo_q  [QW-1];
  logic [NW-1:0] den_q [QW-1];
  logic [QW-1:0] q_q   [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [QW-1:0] lo_in;
    logic [NW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic [NW:0]   r2;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = hi;
      assign lo_in  = lo;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign lo_in  = lo_q[i-1];
      assign den_in = den_q[i-1];
      assign q_in   = q_q[i-1];
    end

    // Shift in the next dividend bit and subtract where it goes
    assign r2 = {rem_in, lo_in[QW-1]};
    assign ge = r2 >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      q_q[i] <= {q_in[QW-2:0], ge};
    end

    if (i < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[i] <= NW'(ge ? r2 - {1'b0, den_in} : r2);
        lo_q[i]  <= {lo_in[QW-2:0], 1'b0};
        den_q[i] <= den_in;
      end
    end
  end

  assign q = q_q[QW-1];

endmodule

FILE: sv/nscas_front.sv
// Front end: takes an item, checks its gates and forms the position differences.
module nscas_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  nscas_pkg::in_t      item,
  output logic                job_vld,
  output nscas_pkg::job_t     job
);

  nscas_pkg::job_t               job_next;
  logic [nscas_pkg::DIST_W-1:0]  dn;
  logic [nscas_pkg::DIST_W-1:0]  de;

  // Classify the item and take the magnitudes apart
  always_comb begin
    job_next.owner = item.is_owner;
    job_next.go    = 1'b0;
    priority if (!item.is_owner)       job_next.rsn = nscas_pkg::RSN_NONE;
    else if (!item.base_valid)         job_next.rsn = nscas_pkg::RSN_BASE_BAD;
    else if (!item.route_is_aim_point) job_next.rsn = nscas_pkg::RSN_NOT_AIM;
    else if (!item.own_position_valid) job_next.rsn = nscas_pkg::RSN_NO_OWN_POS;
    else if (!item.track_available)    job_next.rsn = nscas_pkg::RSN_NO_TRACK;
    else if (!item.track_finite)       job_next.rsn = nscas_pkg::RSN_TRACK_BAD;
    else begin
      job_next.rsn = nscas_pkg::RSN_NONE;
      job_next.go  = 1'b1;
    end
    dn = {item.aim_north[nscas_pkg::POS_W-1], item.aim_north}
       - {item.own_north[nscas_pkg::POS_W-1], item.own_north};
    de = {item.aim_east[nscas_pkg::POS_W-1], item.aim_east}
       - {item.own_east[nscas_pkg::POS_W-1], item.own_east};
    job_next.an     = item.aim_north;
    job_next.ae     = item.aim_east;
    job_next.dn_mag = dn[nscas_pkg::DIST_W-1] ? ~dn + 1'b1 : dn;
    job_next.de_mag = de[nscas_pkg::DIST_W-1] ? ~de + 1'b1 : de;
    job_next.vn_neg = item.track_vel_north[nscas_pkg::VEL_W-1];
    job_next.ve_neg = item.track_vel_east[nscas_pkg::VEL_W-1];
    job_next.vn_mag = job_next.vn_neg ? ~item.track_vel_north + 1'b1 : item.track_vel_north;
    job_next.ve_mag = job_next.ve_neg ? ~item.track_vel_east + 1'b1 : item.track_vel_east;
  end

  // Hold the classified item for the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      job_vld <= 1'b0;
    end else begin
      job_vld <= take;
    end
  end

  always_ff @(posedge clk) begin
    job <= job_next;
  end

endmodule

FILE: sv/nscas_queue.sv
// Short item queue between the front and the back.
module nscas_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  nscas_pkg::job_t  din,
  input  logic             pop,
  output logic             vld,
  output nscas_pkg::job_t  dout,
  output logic             full
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = PW + 1;

  nscas_pkg::job_t mem [DEPTH];
  logic [PW-1:0]   wr;
  logic [PW-1:0]   rd;
  logic [CW-1:0]   count;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push) wr <= wr + 1'b1;
      if (pop)  rd <= rd + 1'b1;
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr] <= din;
  end

  assign vld  = count != '0;
  assign dout = mem[rd];
  // Leave room for the item held in the front register
  assign full = count >= CW'(DEPTH - 1);

endmodule

FILE: sv/nscas_back.sv
// Back end: distance, blend, smoothstep weight and carrot offset, fully pipelined.
module nscas_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_vld,
  input  nscas_pkg::job_t  job,
  input  nscas_pkg::cfg_t  cfg,
  output logic             res_vld,
  output nscas_pkg::out_t  res
);

  localparam int POS_W   = nscas_pkg::POS_W;
  localparam int VEL_W   = nscas_pkg::VEL_W;
  localparam int FRAC_W  = nscas_pkg::FRAC_W;
  localparam int RAD_W   = nscas_pkg::RAD_W;
  localparam int DIST_W  = nscas_pkg::DIST_W;
  localparam int BLEND_W = nscas_pkg::BLEND_W;
  localparam int RW      = DIST_W + 1;
  localparam int SQD_W   = 2 * DIST_W;
  localparam int SQV_W   = 2 * VEL_W;
  localparam int LW_W    = RAD_W + BLEND_W;
  localparam int PC_W    = RAD_W + VEL_W;
  localparam int DV_W    = 2 * VEL_W;
  localparam int SN_W    = POS_W + 2;
  localparam int LAT     = 2 + RW + 1 + FRAC_W + 8 + VEL_W + 1;
  localparam logic [BLEND_W-1:0] ONE  = BLEND_W'(1) << FRAC_W;
  localparam logic [FRAC_W-1:0]  HALF = FRAC_W'(1) << (FRAC_W - 1);
  localparam logic [BLEND_W:0]   THREE_ONE = (BLEND_W+1)'(3) << FRAC_W;

  typedef struct packed {
    logic                     owner;
    logic                     go;
    nscas_pkg::reason_t       rsn;
    logic signed [POS_W-1:0]  an;
    logic signed [POS_W-1:0]  ae;
    logic [VEL_W-1:0]         vn_mag;
    logic [VEL_W-1:0]         ve_mag;
    logic                     vn_neg;
    logic                     ve_neg;
    logic [DIST_W-1:0]        span;
    logic [VEL_W-1:0]         norm;
    logic                     far_ok;
    logic                     geq_far;
    logic                     le_near;
    logic [BLEND_W-1:0]       blend;
    logic [BLEND_W-1:0]       weight;
  } ctx_t;

  ctx_t c_in, c_a, c_b, c_s, c_c, c_v, c_d, c_e, c_f, c_g, c_h, c_i, c_j, c_k, c_q;
  ctx_t c_c_next, c_d_next, c_g_next;
  ctx_t sq_line [RW];
  ctx_t bl_line [FRAC_W];
  ctx_t cr_line [VEL_W];
  logic [LAT-1:0] vpipe;

  logic [SQD_W-1:0]    sq_dn, sq_de;
  logic [SQV_W-1:0]    sq_vn, sq_ve;
  logic [SQD_W:0]      rad_d;
  logic [SQV_W:0]      rad_v;
  logic [RW-1:0]       root_d, root_v;
  logic [DIST_W-1:0]   dist_c;
  logic [VEL_W-1:0]    norm_c;
  logic [RAD_W-1:0]    num, den;
  logic [FRAC_W-1:0]   bq;
  logic [2*BLEND_W-1:0] bb;
  logic [2*BLEND_W-1:0] bb_r;
  logic [BLEND_W:0]    tw;
  logic [2*BLEND_W:0]  p;
  logic [2*BLEND_W:0]  p_r;
  logic [BLEND_W+1:0]  w_raw;
  logic [LW_W-1:0]     lw, lw_r;
  logic [RAD_W-1:0]    len;
  logic [PC_W-1:0]     pn, pe;
  logic [DV_W-1:0]     dvn, dve;
  logic [VEL_W-1:0]    qn, qe;
  logic signed [SN_W-1:0] sn, se;
  logic                ovf;
  nscas_pkg::out_t     res_next;

  always_comb begin
    c_in         = '0;
    c_in.owner   = job.owner;
    c_in.go      = job.go;
    c_in.rsn     = job.rsn;
    c_in.an      = job.an;
    c_in.ae      = job.ae;
    c_in.vn_mag  = job.vn_mag;
    c_in.ve_mag  = job.ve_mag;
    c_in.vn_neg  = job.vn_neg;
    c_in.ve_neg  = job.ve_neg;
  end

  // Track which stages hold an item
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], job_vld};
    end
  end

  // Square the differences and the track components
  always_ff @(posedge clk) begin
    c_a   <= c_in;
    sq_dn <= job.dn_mag * job.dn_mag;
    sq_de <= job.de_mag * job.de_mag;
    sq_vn <= job.vn_mag * job.vn_mag;
    sq_ve <= job.ve_mag * job.ve_mag;
  end

  // Sum the squares
  always_ff @(posedge clk) begin
    c_b   <= c_a;
    rad_d <= {1'b0, sq_dn} + {1'b0, sq_de};
    rad_v <= {1'b0, sq_vn} + {1'b0, sq_ve};
  end

  nscas_isqrt #(.RW(RW)) u_sqrt_dist (
    .clk  (clk),
    .rad  ((2*RW)'(rad_d)),
    .root (root_d)
  );

  nscas_isqrt #(.RW(RW)) u_sqrt_norm (
    .clk  (clk),
    .rad  ((2*RW)'(rad_v)),
    .root (root_v)
  );

  // Carry the context alongside the roots
  always_ff @(posedge clk) begin
    sq_line[0] <= c_b;
    for (int i = 1; i < RW; i++) sq_line[i] <= sq_line[i-1];
  end
  assign c_s = sq_line[RW-1];

  // Saturate the roots and set up the blend division
  always_comb begin
    dist_c = root_d[RW-1] ? '1 : root_d[DIST_W-1:0];
    norm_c = (|root_v[RW-1:VEL_W]) ? '1 : root_v[VEL_W-1:0];
    c_c_next         = c_s;
    c_c_next.span    = dist_c;
    c_c_next.norm    = norm_c;
    c_c_next.far_ok  = cfg.far > cfg.near;
    c_c_next.geq_far = dist_c >= DIST_W'(cfg.far);
    c_c_next.le_near = dist_c <= DIST_W'(cfg.near);
  end

  always_ff @(posedge clk) begin
    c_c <= c_c_next;
    num <= cfg.far - dist_c[RAD_W-1:0];
    den <= cfg.far - cfg.near;
  end

  nscas_div #(.NW(RAD_W), .QW(FRAC_W)) u_div_blend (
    .clk (clk),
    .hi  (num),
    .lo  ('0),
    .den (den),
    .q   (bq)
  );

  always_ff @(posedge clk) begin
    bl_line[0] <= c_c;
    for (int i = 1; i < FRAC_W; i++) bl_line[i] <= bl_line[i-1];
  end
  assign c_v = bl_line[FRAC_W-1];

  // Pick the clamped blend
  always_comb begin
    c_d_next = c_v;
    priority if (!c_v.far_ok || c_v.geq_far) c_d_next.blend = '0;
    else if (c_v.le_near)                    c_d_next.blend = ONE;
    else                                     c_d_next.blend = {1'b0, bq};
  end

  always_ff @(posedge clk) begin
    c_d <= c_d_next;
  end

  // Square the blend and form three minus twice the blend
  always_ff @(posedge clk) begin
    c_e <= c_d;
    bb  <= c_d.blend * c_d.blend;
    tw  <= THREE_ONE - {c_d.blend, 1'b0};
  end

  // Round the square and multiply by three minus twice the blend
  always_comb begin
    bb_r = bb + (2*BLEND_W)'(HALF);
  end

  always_ff @(posedge clk) begin
    c_f <= c_e;
    p   <= bb_r[2*BLEND_W-2:FRAC_W] * tw;
  end

  // Round and limit the weight
  always_comb begin
    p_r   = p + (2*BLEND_W+1)'(HALF);
    w_raw = p_r[2*BLEND_W:FRAC_W];
    c_g_next        = c_f;
    c_g_next.weight = (w_raw > (BLEND_W+2)'(ONE)) ? ONE : w_raw[BLEND_W-1:0];
  end

  always_ff @(posedge clk) begin
    c_g <= c_g_next;
  end

  // Scale the lookahead by the weight
  always_ff @(posedge clk) begin
    c_h <= c_g;
    lw  <= cfg.look * c_g.weight;
  end

  always_comb begin
    lw_r = lw + LW_W'(HALF);
  end

  always_ff @(posedge clk) begin
    c_i <= c_h;
    len <= lw_r[RAD_W+FRAC_W-1:FRAC_W];
  end

  // Carrot length times each track component
  always_ff @(posedge clk) begin
    c_j <= c_i;
    pn  <= len * c_i.vn_mag;
    pe  <= len * c_i.ve_mag;
  end

  // Add half the norm for rounding
  always_ff @(posedge clk) begin
    c_k <= c_j;
    dvn <= DV_W'(pn) + DV_W'(c_j.norm >> 1);
    dve <= DV_W'(pe) + DV_W'(c_j.norm >> 1);
  end

  nscas_div #(.NW(VEL_W), .QW(VEL_W)) u_div_north (
    .clk (clk),
    .hi  (dvn[DV_W-1:VEL_W]),
    .lo  (dvn[VEL_W-1:0]),
    .den (c_k.norm),
    .q   (qn)
  );

  nscas_div #(.NW(VEL_W), .QW(VEL_W)) u_div_east (
    .clk (clk),
    .hi  (dve[DV_W-1:VEL_W]),
    .lo  (dve[VEL_W-1:0]),
    .den (c_k.norm),
    .q   (qe)
  );

  always_ff @(posedge clk) begin
    cr_line[0] <= c_k;
    for (int i = 1; i < VEL_W; i++) cr_line[i] <= cr_line[i-1];
  end
  assign c_q = cr_line[VEL_W-1];

  // Shift the aim point and pick the reason
  always_comb begin
    sn  = SN_W'(c_q.an) + (c_q.vn_neg ? -$signed(SN_W'(qn)) : $signed(SN_W'(qn)));
    se  = SN_W'(c_q.ae) + (c_q.ve_neg ? -$signed(SN_W'(qe)) : $signed(SN_W'(qe)));
    ovf = (sn[SN_W-1:POS_W-1] != '0 && sn[SN_W-1:POS_W-1] != '1)
       || (se[SN_W-1:POS_W-1] != '0 && se[SN_W-1:POS_W-1] != '1);
    res_next = '0;
    res_next.out_north = c_q.an;
    res_next.out_east  = c_q.ae;
    res_next.evaluated = c_q.owner;
    res_next.reason_code = c_q.rsn;
    if (c_q.go) begin
      res_next.station_distance = c_q.span;
      priority if (!c_q.far_ok) begin
        res_next.reason_code = nscas_pkg::RSN_ARITH;
      end else if (c_q.weight == '0) begin
        res_next.reason_code    = nscas_pkg::RSN_BEYOND_FAR;
        res_next.blend_fraction = c_q.blend;
      end else if (c_q.norm <= cfg.nmin) begin
        res_next.reason_code    = nscas_pkg::RSN_TRACK_UNDEF;
        res_next.blend_fraction = c_q.blend;
        res_next.blend_weight   = c_q.weight;
        res_next.track_norm     = c_q.norm;
      end else if (ovf) begin
        res_next.reason_code    = nscas_pkg::RSN_ARITH;
        res_next.blend_fraction = c_q.blend;
        res_next.blend_weight   = c_q.weight;
        res_next.track_norm     = c_q.norm;
      end else begin
        res_next.reason_code    = nscas_pkg::RSN_APPLIED;
        res_next.applied        = 1'b1;
        res_next.out_north      = sn[POS_W-1:0];
        res_next.out_east       = se[POS_W-1:0];
        res_next.blend_fraction = c_q.blend;
        res_next.blend_weight   = c_q.weight;
        res_next.track_norm     = c_q.norm;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  assign res_vld = vpipe[LAT-1];

endmodule

FILE: sv/near_station_carrot_aim_shaper.sv
// Top level of the near-station carrot aim shaper.
// An item taken on start passes the front register, the queue and the back pipeline before its strobe.
// Throughput: one item every cycle; the square root and divider pipelines take one bit a stage.
// The receiver cannot stall, so results leave on fixed timing and busy stays low in use.
// Reset (rst, synchronous, active high) empties the pipeline and loads the default radii.
module near_station_carrot_aim_shaper (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  nscas_pkg::in_t                      item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nscas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nscas_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                strobe,
  output nscas_pkg::out_t                     result
);

  nscas_pkg::cfg_t cfg;
  logic            take;
  logic            job_vld;
  nscas_pkg::job_t job;
  logic            q_vld;
  nscas_pkg::job_t q_job;
  logic            q_full;

  assign cfg_ready = 1'b1;
  assign take      = start & ~busy;
  assign busy      = q_full;

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.far  <= nscas_pkg::RAD_W'(12800);
      cfg.near <= nscas_pkg::RAD_W'(2560);
      cfg.look <= nscas_pkg::RAD_W'(5120);
      cfg.nmin <= nscas_pkg::NMIN_W'(26);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nscas_pkg::CFG_FAR:  cfg.far  <= cfg_data[nscas_pkg::RAD_W-1:0];
        nscas_pkg::CFG_NEAR: cfg.near <= cfg_data[nscas_pkg::RAD_W-1:0];
        nscas_pkg::CFG_LOOK: cfg.look <= cfg_data[nscas_pkg::RAD_W-1:0];
        nscas_pkg::CFG_NMIN: cfg.nmin <= cfg_data[nscas_pkg::NMIN_W-1:0];
        default: ;
      endcase
    end
  end

  nscas_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (item),
    .job_vld (job_vld),
    .job     (job)
  );

  nscas_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (job_vld),
    .din  (job),
    .pop  (q_vld),
    .vld  (q_vld),
    .dout (q_job),
    .full (q_full)
  );

  nscas_back u_back (
    .clk     (clk),
    .rst     (rst),
    .job_vld (q_vld),
    .job     (q_job),
    .cfg     (cfg),
    .res_vld (strobe),
    .res     (result)
  );

  a_applied_reason: assert property (@(posedge clk) disable iff (rst)
    strobe && result.applied |-> result.reason_code == nscas_pkg::RSN_APPLIED)
    else $error("applied result without applied reason");

  a_idle_owner: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.evaluated |->
      result.reason_code == nscas_pkg::RSN_NONE && result.station_distance == '0)
    else $error("unowned item carries results");

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("queue backed up");

endmodule
